// ===== hdl/multiplexed_segment_serial_driver_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the segment serial driver
// Shared clocked assertion wrappers; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MULTIPLEXED_SEGMENT_SERIAL_DRIVER_UNIT_DEFINES_SVH
`define MULTIPLEXED_SEGMENT_SERIAL_DRIVER_UNIT_DEFINES_SVH

// checked outside reset only
`define MSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg
// Types, constants and lookup functions of the segment serial driver.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int WORD_BITS = 16;

  // one accepted input transaction as seen by the scan core
  typedef struct packed {
    logic       tick;
    logic       write;
    logic [1:0] digit_index;
    logic [3:0] digit_value;
  } msd_step_t;

  typedef struct packed {
    logic       serial_data;
    logic       shift_clock;
    logic       latch_enable;
    logic [3:0] digit_enable;
    logic       frame_last;
  } msd_result_t;

  // hex value -> segment pattern, bit0 = A .. bit6 = G, bit7 = dot
  function automatic logic [7:0] seg_lut(input logic [3:0] hex);
    logic [7:0] pat;
    unique case (hex)
      4'h0: pat = 8'h3F;
      4'h1: pat = 8'h06;
      4'h2: pat = 8'h5B;
      4'h3: pat = 8'h4F;
      4'h4: pat = 8'h66;
      4'h5: pat = 8'h6D;
      4'h6: pat = 8'h7D;
      4'h7: pat = 8'h07;
      4'h8: pat = 8'h7F;
      4'h9: pat = 8'h6F;
      4'hA: pat = 8'h77;
      4'hB: pat = 8'h7C;
      4'hC: pat = 8'h39;
      4'hD: pat = 8'h5E;
      4'hE: pat = 8'h79;
      4'hF: pat = 8'h71;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

  // driver channel 0..7 -> pattern bit wired to it
  function automatic logic [2:0] chan_bit(input logic [2:0] chan);
    logic [2:0] b;
    unique case (chan)
      3'd0: b = 3'd6;
      3'd1: b = 3'd2;
      3'd2: b = 3'd1;
      3'd3: b = 3'd7;
      3'd4: b = 3'd3;
      3'd5: b = 3'd5;
      3'd6: b = 3'd4;
      3'd7: b = 3'd0;
      default: b = 3'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/msd_if.sv =====
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for input items, results and the dwell register.
// ----------------------------------------------------------------------------
interface msd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [1:0] digit_index;
  logic [3:0] digit_value;

  modport source (output valid, mode, digit_index, digit_value, input ready);
  modport sink   (input valid, mode, digit_index, digit_value, output ready);
endinterface

interface msd_out_if;
  logic       valid;
  logic       ready;
  logic       serial_data;
  logic       shift_clock;
  logic       latch_enable;
  logic [3:0] digit_enable;
  logic       frame_last;

  modport source (output valid, serial_data, shift_clock, latch_enable, digit_enable,
                  frame_last, input ready);
  modport sink   (input valid, serial_data, shift_clock, latch_enable, digit_enable,
                  frame_last, output ready);
endinterface

interface msd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/msd_scan_core.sv =====
// ----------------------------------------------------------------------------
// msd_scan_core
// Digit store, scan position and frame/dwell sequencing; one step per tick.
// ----------------------------------------------------------------------------
module msd_scan_core #(
  parameter int NUM_DIGITS   = 4,
  parameter int NUM_CHANNELS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  msd_pkg::msd_step_t   step,
  input  logic [15:0]          dwell_ticks,
  output msd_pkg::msd_result_t result
);
  import msd_pkg::*;

  localparam int FRAME_BITS = NUM_CHANNELS * WORD_BITS;
  localparam int BP_W       = $clog2(FRAME_BITS);
  localparam int WORD_W     = BP_W - 4;
  localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic [3:0]        digit_store_r [NUM_DIGITS];
  logic [DIG_W-1:0]  scan_r, scan_nxt;
  logic [BP_W-1:0]   bitpos_r, bitpos_nxt;
  logic [15:0]       dwell_cnt_r, dwell_cnt_nxt;
  logic              in_dwell_r, in_dwell_nxt;
  logic [7:0]        seg_r, seg_nxt;

  logic [7:0]        pat;
  logic [WORD_W-1:0] word;
  logic [3:0]        bit_in_word;
  logic [WORD_W-1:0] chan;
  logic              chan_lit;
  logic              final_word;
  logic              frame_end;
  logic [16:0]       dwell_inc;
  logic              dwell_done;
  logic [DIG_W-1:0]  scan_adv;
  logic [3:0]        en;

  always_comb begin
    pat         = (bitpos_r == '0) ? seg_lut(digit_store_r[scan_r]) : seg_r;
    word        = bitpos_r[BP_W-1:4];
    bit_in_word = bitpos_r[3:0];
    chan        = WORD_W'(NUM_CHANNELS - 1) - word;
    // only channels 0..7 carry segments
    chan_lit    = ({1'b0, chan} < (WORD_W + 1)'(8)) && pat[chan_bit(chan[2:0])];
    final_word  = (word == WORD_W'(NUM_CHANNELS - 1));
    frame_end   = (bitpos_r == BP_W'(FRAME_BITS - 1));
    dwell_inc   = {1'b0, dwell_cnt_r} + 17'd1;
    dwell_done  = (dwell_inc >= {1'b0, dwell_ticks});
    scan_adv    = (scan_r == DIG_W'(NUM_DIGITS - 1)) ? '0 : scan_r + DIG_W'(1);
    for (int k = 0; k < 4; k++) begin
      en[k] = (32'(scan_r) == k);
    end
  end

  always_comb begin
    scan_nxt      = scan_r;
    bitpos_nxt    = bitpos_r;
    dwell_cnt_nxt = dwell_cnt_r;
    in_dwell_nxt  = in_dwell_r;
    seg_nxt       = seg_r;
    result        = '0;
    if (!in_dwell_r) begin
      result.serial_data  = chan_lit;
      result.shift_clock  = 1'b1;
      result.latch_enable = (bit_in_word == 4'd15) || (final_word && bit_in_word == 4'd14);
      seg_nxt             = pat;
      bitpos_nxt          = bitpos_r + BP_W'(1);
      if (frame_end) begin
        bitpos_nxt    = '0;
        dwell_cnt_nxt = '0;
        if (dwell_ticks == 16'd0) begin
          result.frame_last = 1'b1;
          scan_nxt          = scan_adv;
        end else begin
          in_dwell_nxt = 1'b1;
        end
      end
    end else begin
      result.digit_enable = en;
      dwell_cnt_nxt       = dwell_inc[15:0];
      if (dwell_done) begin
        result.frame_last = 1'b1;
        scan_nxt          = scan_adv;
        bitpos_nxt        = '0;
        dwell_cnt_nxt     = '0;
        in_dwell_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      bitpos_r    <= '0;
      dwell_cnt_r <= '0;
      in_dwell_r  <= 1'b0;
      seg_r       <= '0;
    end else if (step.tick) begin
      scan_r      <= scan_nxt;
      bitpos_r    <= bitpos_nxt;
      dwell_cnt_r <= dwell_cnt_nxt;
      in_dwell_r  <= in_dwell_nxt;
      seg_r       <= seg_nxt;
    end
  end

  // writes land in the store and show at the next frame start
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (!rst_n) begin
        digit_store_r[k] <= 4'(k);
      end else if (step.write && 32'(step.digit_index) == k) begin
        digit_store_r[k] <= step.digit_value;
      end
    end
  end

endmodule

// ===== hdl/multiplexed_segment_serial_driver_unit.sv =====
// ----------------------------------------------------------------------------
// multiplexed_segment_serial_driver_unit
// Scans multiplexed seven-segment digits through a serial LED driver.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                       | per item
//  in_ch    | in  | mode, digit_index, digit_value                | tick or write
//  out_ch   | out | serial_data, shift_clock, latch_enable,       | one per tick
//           |     | digit_enable, frame_last                      |
//  cfg_ch   | in  | data = dwell_ticks                            | register write
//
//  One transaction per cycle sustained while the output is not stalled; a tick result
//  passes through the input register feeding the scan core, then the result register.
//  Write transactions pass through the same register and give no result.
//  A stalled output only holds back ticks once the input register is full.
//  Synchronous active-low reset; dwell_ticks resets to 1024, digits to 0,1,2,...
// ----------------------------------------------------------------------------
`include "multiplexed_segment_serial_driver_unit_defines.svh"

module multiplexed_segment_serial_driver_unit #(
  parameter int NUM_DIGITS   = 4,
  parameter int NUM_CHANNELS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  msd_in_if.sink    in_ch,
  msd_out_if.source out_ch,
  msd_cfg_if.sink   cfg_ch
);
  import msd_pkg::*;

  logic        in_valid_r;
  logic        in_mode_r;
  logic [1:0]  in_index_r;
  logic [3:0]  in_value_r;
  logic        out_valid_r;
  msd_result_t res_r;
  msd_result_t core_res;
  msd_step_t   step;
  logic [15:0] dwell_ticks_r;
  logic        adv;

  // a write never needs output space
  assign adv          = in_valid_r && (in_mode_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || adv;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    step.tick        = adv && !in_mode_r;
    step.write       = adv && in_mode_r;
    step.digit_index = in_index_r;
    step.digit_value = in_value_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_ticks_r <= 16'd1024;
    end else if (cfg_ch.valid) begin
      dwell_ticks_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_mode_r  <= in_ch.mode;
      in_index_r <= in_ch.digit_index;
      in_value_r <= in_ch.digit_value;
    end
  end

  msd_scan_core #(
    .NUM_DIGITS   (NUM_DIGITS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .dwell_ticks (dwell_ticks_r),
    .result      (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step.tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.tick) begin
      res_r <= core_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.serial_data  = res_r.serial_data;
  assign out_ch.shift_clock  = res_r.shift_clock;
  assign out_ch.latch_enable = res_r.latch_enable;
  assign out_ch.digit_enable = res_r.digit_enable;
  assign out_ch.frame_last   = res_r.frame_last;

  `MSD_ASSERT(a_write_no_result, (step.write && out_valid_r && out_ch.ready) |=> !out_valid_r, "write transaction produced a result")
  `MSD_ASSERT(a_enable_not_shifting, out_valid_r |-> !(res_r.shift_clock && res_r.digit_enable != 4'd0), "digit lit while shifting")
  `MSD_ASSERT(a_latch_with_clock, out_valid_r && res_r.latch_enable |-> res_r.shift_clock, "latch enable outside a shift bit")
  `MSD_ASSERT_ALWAYS(a_no_tick_on_full_stall, (out_valid_r && !out_ch.ready) |-> !step.tick, "tick advanced into a stalled output")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Segment scan driver testbench
// Feeds tick and digit-write transactions into the scan unit with random
// sender bursts and receiver stalls. An in-bench scan model predicts every
// bit period, and each result is checked field by field. Directed tests
// cover the reset dwell, zero and maximum dwell, and cutting a dwell short.
// A random phase then walks many dwell settings.
// ----------------------------------------------------------------------------
module testbench;
  import msd_pkg::*;

  localparam int FRAME_TICKS  = 256;
  localparam int DRAIN_CYCLES = 4;
  localparam int LIMIT_CYCLES = 500000;
  localparam int RANDOM_ITEMS = 270;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // hex digit -> segment pattern, digit F in the top byte
  localparam logic [127:0] SEG_ROM = {
    8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
    8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };
  // driver channel -> segment bit, channel 7 in the top field
  localparam logic [23:0] CHAN_SEG = {3'd0, 3'd4, 3'd5, 3'd3, 3'd7, 3'd1, 3'd2, 3'd6};

  logic clk;
  logic rst_n;

  msd_in_if  in_ch ();
  msd_out_if out_ch ();
  msd_cfg_if cfg_ch ();

  multiplexed_segment_serial_driver_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // scan model state
  logic [15:0] dwell_reg;
  logic [3:0]  digit_vals [4];
  logic [1:0]  scan_pos;
  int          bit_pos;
  int          dwell_cnt;
  logic        dwelling;
  logic [7:0]  seg_pat;

  msd_result_t pending_ticks [$];

  int   cycle = 0;
  int   errors = 0;
  int   ticks_sent = 0;
  int   writes_sent = 0;
  int   dwell_writes = 0;
  int   checked = 0;
  int   frames_done = 0;
  int   burst_left = 0;
  logic tx_steady;
  logic rx_steady;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 30)
      $display("cycle %0d: %s got %0h want %0h", cycle, what, got, want);
  endtask

  task automatic scan_model_reset();
    dwell_reg = 16'd1024;
    for (int i = 0; i < 4; i++)
      digit_vals[i] = 4'(i);
    scan_pos  = 2'd0;
    bit_pos   = 0;
    dwell_cnt = 0;
    dwelling  = 1'b0;
    seg_pat   = 8'h00;
  endtask

  task automatic scan_advance();
    scan_pos  = scan_pos + 2'd1;
    bit_pos   = 0;
    dwell_cnt = 0;
    dwelling  = 1'b0;
  endtask

  // one accepted transaction: a write updates the store, a tick yields a result
  task automatic scan_predict(input logic m, input logic [1:0] idx, input logic [3:0] val);
    msd_result_t r;
    int word;
    int slot;
    int chan;
    r = '0;
    if (m == MODE_WRITE) begin
      digit_vals[idx] = val;
      writes_sent++;
      return;
    end
    if (!dwelling) begin
      if (bit_pos == 0)
        seg_pat = SEG_ROM[digit_vals[scan_pos]*8 +: 8];
      word = bit_pos / 16;
      slot = bit_pos % 16;
      chan = 15 - word;
      if (chan < 8)
        r.serial_data = seg_pat[CHAN_SEG[chan*3 +: 3]];
      r.shift_clock  = 1'b1;
      r.latch_enable = (slot == 15) || (word == 15 && slot == 14);
      bit_pos++;
      if (bit_pos >= FRAME_TICKS) begin
        if (dwell_reg == 16'd0) begin
          r.frame_last = 1'b1;
          scan_advance();
        end else begin
          dwelling  = 1'b1;
          dwell_cnt = 0;
        end
      end
    end else begin
      r.digit_enable = 4'b0001 << scan_pos;
      dwell_cnt++;
      if (dwell_cnt >= int'(dwell_reg)) begin
        r.frame_last = 1'b1;
        scan_advance();
      end
    end
    pending_ticks.push_back(r);
    ticks_sent++;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    msd_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_ticks.size() == 0) begin
        flag_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pending_ticks.pop_front();
        checked++;
        if (out_ch.serial_data !== want.serial_data)
          flag_mismatch("serial_data", out_ch.serial_data, want.serial_data);
        if (out_ch.shift_clock !== want.shift_clock)
          flag_mismatch("shift_clock", out_ch.shift_clock, want.shift_clock);
        if (out_ch.latch_enable !== want.latch_enable)
          flag_mismatch("latch_enable", out_ch.latch_enable, want.latch_enable);
        if (out_ch.digit_enable !== want.digit_enable)
          flag_mismatch("digit_enable", out_ch.digit_enable, want.digit_enable);
        if (out_ch.frame_last !== want.frame_last)
          flag_mismatch("frame_last", out_ch.frame_last, want.frame_last);
        if (want.frame_last)
          frames_done++;
      end
    end
  end

  // receiver: alternating ready runs and stalls, occasionally long ones
  initial begin : receiver
    logic rx_on;
    int   rx_left;
    rx_on = 1'b1;
    rx_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_on = !rx_on;
        if (rx_on)
          rx_left = $urandom_range(1, 24);
        else if ($urandom_range(0, 9) == 0)
          rx_left = $urandom_range(12, 30);
        else
          rx_left = $urandom_range(1, 4);
      end
      rx_left--;
      out_ch.ready <= rx_on || rx_steady;
    end
  end

  task automatic send_item(input logic m, input logic [1:0] idx, input logic [3:0] val);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!tx_steady)
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid       <= 1'b0;
      in_ch.mode        <= 1'($urandom);
      in_ch.digit_index <= 2'($urandom);
      in_ch.digit_value <= 4'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.digit_index <= idx;
    in_ch.digit_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    scan_predict(m, idx, val);
  endtask

  // tick payload fields are don't-care, so they carry noise
  task automatic send_ticks(input int n);
    repeat (n) send_item(MODE_TICK, 2'($urandom), 4'($urandom));
  endtask

  // hold the sender until every pending result is back, then let the core settle
  task automatic settle_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dwell(input logic [15:0] v);
    settle_results();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    dwell_reg = v;
    dwell_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // digit 0 frame at the reset dwell, then the dwell is cut short mid-dwell
  task automatic test_reset_dwell();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_ticks(FRAME_TICKS + 4);
    write_dwell(16'd2);
    send_ticks(1);
  endtask

  // zero dwell: frames back to back, writes at extremes, one mid-frame write
  task automatic test_frame_walk();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    write_dwell(16'd0);
    send_item(MODE_WRITE, 2'd0, 4'hA);
    send_item(MODE_WRITE, 2'd1, 4'hF);
    send_item(MODE_WRITE, 2'd2, 4'h8);
    send_item(MODE_WRITE, 2'd3, 4'h0);
    send_ticks(100);
    // shows up on digit 1's next frame only
    send_item(MODE_WRITE, 2'd1, 4'h7);
    send_ticks(FRAME_TICKS - 100 + FRAME_TICKS);
  endtask

  // maximum dwell on digit 3, then a shorter dwell ends it at once
  task automatic test_long_dwell();
    send_item(MODE_WRITE, 2'd3, 4'h5);
    write_dwell(16'hFFFF);
    send_ticks(FRAME_TICKS + 40);
    write_dwell(16'd30);
    send_ticks(3);
  endtask

  task automatic test_random_traffic();
    int budget;
    int n;
    logic [15:0] d;
    budget = RANDOM_ITEMS;
    while (budget > 0) begin
      case ($urandom_range(0, 9))
        0: d = 16'd0;
        1: d = 16'd1;
        2: d = 16'hFFFF;
        3: d = 16'($urandom);
        4: d = 16'($urandom_range(2, 8));
        default: d = 16'($urandom_range(0, 60));
      endcase
      write_dwell(d);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(60, 320);
      if (n > budget)
        n = budget;
      repeat (n) begin
        if ($urandom_range(0, 9) == 0)
          send_item(MODE_WRITE, 2'($urandom), 4'($urandom));
        else
          send_item(MODE_TICK, 2'($urandom), 4'($urandom));
        budget--;
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_TICK;
    in_ch.digit_index = 2'd0;
    in_ch.digit_value = 4'd0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = 16'd0;
    tx_steady         = 1'b1;
    rx_steady         = 1'b1;
    scan_model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_dwell();
    test_frame_walk();
    test_long_dwell();
    test_random_traffic();
    settle_results();

    $display("%0d tick and %0d digit-write transactions over %0d dwell settings",
             ticks_sent, writes_sent, dwell_writes + 1);
    $display("%0d results checked, %0d digit frames ended, %0d mismatches",
             checked, frames_done, errors);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
